// ===== rtl/core/brm_pkg.sv =====
// Shared constants for the radix-2 Booth multiplier core.
`default_nettype none

package brm_pkg;

   // Fixed field widths of the request, response and control ports
   localparam int IN_W      = 16;
   localparam int PRODUCT_W = 32;
   localparam int MAG_W     = 31;
   localparam int CFG_W     = 5;

   // Operand width after reset and the smallest width the core honors
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
   localparam logic [CFG_W-1:0] MIN_WIDTH = 5'd2;

   // Booth rounds folded into one pipeline stage
   localparam int ROUNDS_PER_STAGE = 2;

endpackage

`default_nettype wire

// ===== rtl/core/brm_req_if.sv =====
// Request channel: operand pair with valid/ready handshake.
`default_nettype none

interface brm_req_if;
   logic                     valid;
   logic                     ready;
   logic [brm_pkg::IN_W-1:0] multiplicand_bits;
   logic [brm_pkg::IN_W-1:0] multiplier_bits;

   modport source (output valid, output multiplicand_bits, output multiplier_bits,
                   input ready);
   modport sink   (input valid, input multiplicand_bits, input multiplier_bits,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brm_rsp_if.sv =====
// Response channel: product, sign and magnitude with valid/ready handshake.
`default_nettype none

interface brm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [brm_pkg::PRODUCT_W-1:0] product_bits;
   logic                          negative;
   logic [brm_pkg::MAG_W-1:0]     magnitude;

   modport source (output valid, output product_bits, output negative, output magnitude,
                   input ready);
   modport sink   (input valid, input product_bits, input negative, input magnitude,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brm_prep.sv =====
// Entry stage: clamp the operand width, build the width mask, trim the operands.
`default_nettype none

module brm_prep #(
   parameter int W  = 16,
   parameter int NW = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [brm_pkg::IN_W-1:0]  in_mcand,
   input  logic [brm_pkg::IN_W-1:0]  in_mplier,
   input  logic [brm_pkg::CFG_W-1:0] cfg_width,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [W-1:0]              out_mcand,
   output logic [W-1:0]              out_mplier,
   output logic [W-1:0]              out_mask,
   output logic [NW-1:0]             out_width
);

   localparam int CW = brm_pkg::CFG_W;

   logic                 valid_ff;
   logic [W-1:0]         mcand_ff, mcand_in;
   logic [W-1:0]         mplier_ff, mplier_in;
   logic [W-1:0]         mask_ff, mask_in;
   logic [NW-1:0]        width_ff, width_in;
   logic [CW-1:0]        width_clamped;

   always_comb begin
      if (cfg_width < brm_pkg::MIN_WIDTH) begin
         width_clamped = brm_pkg::MIN_WIDTH;
      end else if (cfg_width > CW'(W)) begin
         width_clamped = CW'(W);
      end else begin
         width_clamped = cfg_width;
      end
      for (int i = 0; i < W; i++) begin
         mask_in[i] = (CW'(i) < width_clamped);
      end
      width_in  = NW'(width_clamped);
      mcand_in  = W'(in_mcand) & mask_in;
      mplier_in = W'(in_mplier) & mask_in;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mcand_ff  <= mcand_in;
         mplier_ff <= mplier_in;
         mask_ff   <= mask_in;
         width_ff  <= width_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_mcand  = mcand_ff;
   assign out_mplier = mplier_ff;
   assign out_mask   = mask_ff;
   assign out_width  = width_ff;

endmodule

`default_nettype wire

// ===== rtl/core/brm_booth_stage.sv =====
// One pipeline stage of Booth rounds on the A:Q:q register triple.
`default_nettype none

module brm_booth_stage #(
   parameter int W     = 16,
   parameter int NW    = 5,
   parameter int FIRST = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [W-1:0]  in_acc,
   input  logic [W-1:0]  in_mplier,
   input  logic          in_extra,
   input  logic [W-1:0]  in_mcand,
   input  logic [W-1:0]  in_mask,
   input  logic [NW-1:0] in_width,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [W-1:0]  out_acc,
   output logic [W-1:0]  out_mplier,
   output logic          out_extra,
   output logic [W-1:0]  out_mcand,
   output logic [W-1:0]  out_mask,
   output logic [NW-1:0] out_width
);

   localparam int SPAN = W - FIRST;
   localparam int HERE = (SPAN < brm_pkg::ROUNDS_PER_STAGE) ? SPAN
                                                             : brm_pkg::ROUNDS_PER_STAGE;

   logic          valid_ff;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  q_ff, q_in;
   logic          extra_ff, extra_in;
   logic [W-1:0]  mcand_ff;
   logic [W-1:0]  mask_ff;
   logic [NW-1:0] width_ff;
   logic [W-1:0]  top;

   // Round r runs only while r is below the operand width (mask bit r set).
   always_comb begin
      top      = in_mask & ~(in_mask >> 1);
      acc_in   = in_acc;
      q_in     = in_mplier;
      extra_in = in_extra;
      for (int j = 0; j < HERE; j++) begin
         if (in_mask[FIRST + j]) begin
            if (!q_in[0] && extra_in) begin
               acc_in = (acc_in + in_mcand) & in_mask;
            end else if (q_in[0] && !extra_in) begin
               acc_in = (acc_in - in_mcand) & in_mask;
            end
            extra_in = q_in[0];
            q_in     = (q_in >> 1) | ({W{acc_in[0]}} & top);
            acc_in   = (acc_in >> 1) | (acc_in & top);
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         acc_ff   <= acc_in;
         q_ff     <= q_in;
         extra_ff <= extra_in;
         mcand_ff <= in_mcand;
         mask_ff  <= in_mask;
         width_ff <= in_width;
      end
   end

   assign out_valid  = valid_ff;
   assign out_acc    = acc_ff;
   assign out_mplier = q_ff;
   assign out_extra  = extra_ff;
   assign out_mcand  = mcand_ff;
   assign out_mask   = mask_ff;
   assign out_width  = width_ff;

endmodule

`default_nettype wire

// ===== rtl/core/brm_finish.sv =====
// Output stage: join A:Q into the product, derive sign and magnitude, hold the beat.
`default_nettype none

module brm_finish #(
   parameter int W  = 16,
   parameter int NW = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [W-1:0]                  in_acc,
   input  logic [W-1:0]                  in_mplier,
   input  logic [W-1:0]                  in_mask,
   input  logic [NW-1:0]                 in_width,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [brm_pkg::PRODUCT_W-1:0] out_product,
   output logic                          out_negative,
   output logic [brm_pkg::MAG_W-1:0]     out_magnitude
);

   localparam int PW  = 2 * W;
   localparam int POW = brm_pkg::PRODUCT_W;
   localparam int MOW = brm_pkg::MAG_W;

   logic           valid_ff;
   logic [POW-1:0] product_ff, product_in;
   logic           negative_ff, negative_in;
   logic [MOW-1:0] magnitude_ff, magnitude_in;
   logic [W-1:0]   top;
   logic [PW-1:0]  wide;
   logic [PW-1:0]  wide_mask;
   logic [PW-1:0]  wide_mag;

   always_comb begin
      top          = in_mask & ~(in_mask >> 1);
      wide         = ({{W{1'b0}}, in_acc} << in_width) | {{W{1'b0}}, in_mplier};
      wide_mask    = ({{W{1'b0}}, in_mask} << in_width) | {{W{1'b0}}, in_mask};
      negative_in  = |(in_acc & top);
      wide_mag     = negative_in ? ((-wide) & wide_mask) : wide;
      product_in   = POW'(wide);
      magnitude_in = MOW'(wide_mag);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         product_ff   <= product_in;
         negative_ff  <= negative_in;
         magnitude_ff <= magnitude_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_product   = product_ff;
   assign out_negative  = negative_ff;
   assign out_magnitude = magnitude_ff;

endmodule

`default_nettype wire

// ===== rtl/core/booth_radix2_multiplier_core.sv =====
// Top level of the pipelined radix-2 Booth signed multiplier.
//
//   channel   direction  handshake          payload
//   req_port  in         valid/ready        multiplicand_bits[15:0], multiplier_bits[15:0]
//   rsp_port  out        valid/ready        product_bits[31:0], negative, magnitude[30:0]
//   csr_*     in         write enable only  operand_bits[4:0]
//
// One beat enters and one leaves per cycle, sustained, while rsp_port.ready stays high.
// The pipeline has one entry stage, one stage per two Booth rounds (at most one add or
// subtract each), and one output stage.
// Reset clears every stage valid bit and sets operand_bits to 16; no clearing pass.
// With rsp_port.ready low the output beat holds and empty stages behind it still fill;
// req_port.ready drops only when every stage holds a beat.
`default_nettype none

module booth_radix2_multiplier_core #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   brm_req_if.sink                   req_port,
   brm_rsp_if.source                 rsp_port,
   input  logic                      csr_write_enable,
   input  logic [brm_pkg::CFG_W-1:0] csr_write_data
);

   localparam int W   = MAX_WIDTH;
   localparam int NW  = $clog2(W + 1);
   localparam int RPS = brm_pkg::ROUNDS_PER_STAGE;
   localparam int NS  = (W + RPS - 1) / RPS;

   logic [brm_pkg::CFG_W-1:0] operand_bits_ff;

   // Stage k feeds Booth stage k; index NS feeds the output stage.
   logic [NS:0]   st_valid;
   logic [NS:0]   st_ready;
   logic [W-1:0]  st_acc    [NS+1];
   logic [W-1:0]  st_mplier [NS+1];
   logic          st_extra  [NS+1];
   logic [W-1:0]  st_mcand  [NS+1];
   logic [W-1:0]  st_mask   [NS+1];
   logic [NW-1:0] st_width  [NS+1];

   // Operand width register; the user must write it only while the pipeline is drained; the core does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         operand_bits_ff <= brm_pkg::CFG_RESET;
      end else if (csr_write_enable) begin
         operand_bits_ff <= csr_write_data;
      end
   end

   // Entry stage: trim operands to the active width and start with A and q at zero.
   brm_prep #(
      .W  (W),
      .NW (NW)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_port.valid),
      .in_ready   (req_port.ready),
      .in_mcand   (req_port.multiplicand_bits),
      .in_mplier  (req_port.multiplier_bits),
      .cfg_width  (operand_bits_ff),
      .out_valid  (st_valid[0]),
      .out_ready  (st_ready[0]),
      .out_mcand  (st_mcand[0]),
      .out_mplier (st_mplier[0]),
      .out_mask   (st_mask[0]),
      .out_width  (st_width[0])
   );

   assign st_acc[0]   = '0;
   assign st_extra[0] = 1'b0;

   // Booth rounds, two per stage; a stage past the active width passes its beat through.
   for (genvar k = 0; k < NS; k++) begin : g_booth
      brm_booth_stage #(
         .W     (W),
         .NW    (NW),
         .FIRST (k * RPS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (st_valid[k]),
         .in_ready   (st_ready[k]),
         .in_acc     (st_acc[k]),
         .in_mplier  (st_mplier[k]),
         .in_extra   (st_extra[k]),
         .in_mcand   (st_mcand[k]),
         .in_mask    (st_mask[k]),
         .in_width   (st_width[k]),
         .out_valid  (st_valid[k+1]),
         .out_ready  (st_ready[k+1]),
         .out_acc    (st_acc[k+1]),
         .out_mplier (st_mplier[k+1]),
         .out_extra  (st_extra[k+1]),
         .out_mcand  (st_mcand[k+1]),
         .out_mask   (st_mask[k+1]),
         .out_width  (st_width[k+1])
      );
   end

   // Output stage: the registered result doubles as the skid toward the sink.
   brm_finish #(
      .W  (W),
      .NW (NW)
   ) u_finish (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (st_valid[NS]),
      .in_ready      (st_ready[NS]),
      .in_acc        (st_acc[NS]),
      .in_mplier     (st_mplier[NS]),
      .in_mask       (st_mask[NS]),
      .in_width      (st_width[NS]),
      .out_valid     (rsp_port.valid),
      .out_ready     (rsp_port.ready),
      .out_product   (rsp_port.product_bits),
      .out_negative  (rsp_port.negative),
      .out_magnitude (rsp_port.magnitude)
   );

`ifndef SYNTH
   // Reset empties the output stage.
   a_reset_drains_output: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("output beat valid after reset");

   // An accepted request lands in the entry stage on the next edge.
   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> st_valid[0])
      else $error("accepted request missing from entry stage");

   // Back-pressure on the request side only with a full pipe and a stalled sink.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> (&st_valid) && rsp_port.valid && !rsp_port.ready)
      else $error("request stalled while a stage is free");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the radix-2 Booth multiplier core.
module tb;

   // Core parameter and derived run constants.
   localparam int MAX_WIDTH     = 16;
   localparam int LATENCY       = (MAX_WIDTH + 1) / 2 + 2;
   localparam int SETTLE_CYCLES = 2 * LATENCY;
   localparam int RAND_PHASES   = 9;
   localparam int PHASE_BEATS   = 90;
   localparam int HOLD_CYCLES   = 60;
   localparam int DIRECTED_16   = 10;

   // Directed operand pairs at the reset width of 16 bits: zero, extreme
   // positive and negative values, minus one and long runs of Booth
   // add/subtract transitions.
   localparam logic [brm_pkg::IN_W-1:0] DIR_MCAND [DIRECTED_16] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF,
      16'hFFFF, 16'h0001, 16'h1234, 16'hAAAA, 16'h5555};
   localparam logic [brm_pkg::IN_W-1:0] DIR_MPLIER [DIRECTED_16] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF,
      16'h0001, 16'h8000, 16'h0000, 16'h5555, 16'hAAAA};

   // One expected or observed result beat.
   typedef struct packed {
      logic [brm_pkg::PRODUCT_W-1:0] product_bits;
      logic                          negative;
      logic [brm_pkg::MAG_W-1:0]     magnitude;
   } product_type;

   // Holds predicted products in acceptance order and checks each result beat.
   class product_scoreboard_type;
      product_type expected_products[$];
      int unsigned failures;
      int unsigned checked;

      function new();
         failures = 0;
         checked  = 0;
      endfunction

      static function int unsigned effective_width(logic [brm_pkg::CFG_W-1:0] width_cfg);
         int unsigned n;
         n = 32'(width_cfg);
         if (n < 32'(brm_pkg::MIN_WIDTH)) n = 32'(brm_pkg::MIN_WIDTH);
         if (n > MAX_WIDTH) n = MAX_WIDTH;
         return n;
      endfunction

      // Radix-2 Booth recoding on A:Q:q, n rounds, arithmetic shift each round.
      static function product_type booth_product(logic [brm_pkg::IN_W-1:0] mcand_in,
                                                 logic [brm_pkg::IN_W-1:0] mplier_in,
                                                 logic [brm_pkg::CFG_W-1:0] width_cfg);
         int unsigned n;
         int unsigned rnd;
         logic [63:0] mask;
         logic [63:0] top;
         logic [63:0] mcand;
         logic [63:0] acc;
         logic [63:0] qreg;
         logic        extra;
         logic [63:0] prod_mask;
         logic [63:0] prod;
         logic [63:0] mag;
         product_type res;
         n         = effective_width(width_cfg);
         mask      = (64'd1 << n) - 64'd1;
         top       = 64'd1 << (n - 1);
         mcand     = {48'd0, mcand_in} & mask;
         qreg      = {48'd0, mplier_in} & mask;
         acc       = 64'd0;
         extra     = 1'b0;
         prod_mask = (64'd1 << (2 * n)) - 64'd1;
         for (rnd = 0; rnd < n; rnd++) begin
            if (!qreg[0] && extra)
               acc = (acc + mcand) & mask;
            else if (qreg[0] && !extra)
               acc = (acc - mcand) & mask;
            extra = qreg[0];
            qreg  = (qreg >> 1) | ({63'd0, acc[0]} << (n - 1));
            acc   = (acc >> 1) | (acc & top);
         end
         prod             = ((acc << n) | qreg) & prod_mask;
         res.negative     = prod[2 * n - 1];
         mag              = res.negative ? ((64'd0 - prod) & prod_mask) : prod;
         res.product_bits = prod[brm_pkg::PRODUCT_W-1:0];
         res.magnitude    = mag[brm_pkg::MAG_W-1:0];
         return res;
      endfunction

      function void note_operands(logic [brm_pkg::IN_W-1:0] mcand,
                                  logic [brm_pkg::IN_W-1:0] mplier,
                                  logic [brm_pkg::CFG_W-1:0] width_cfg);
         expected_products.push_back(booth_product(mcand, mplier, width_cfg));
      endfunction

      function void check_product(logic [brm_pkg::PRODUCT_W-1:0] product_bits,
                                  logic negative,
                                  logic [brm_pkg::MAG_W-1:0] magnitude);
         product_type want;
         if (expected_products.size() == 0) begin
            $error("product beat with nothing outstanding: product_bits %h", product_bits);
            failures++;
            return;
         end
         want = expected_products.pop_front();
         checked++;
         if (product_bits !== want.product_bits) begin
            $error("product_bits: expected %h, got %h", want.product_bits, product_bits);
            failures++;
         end
         if (negative !== want.negative) begin
            $error("negative: expected %b, got %b", want.negative, negative);
            failures++;
         end
         if (magnitude !== want.magnitude) begin
            $error("magnitude: expected %h, got %h", want.magnitude, magnitude);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_products.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [brm_pkg::CFG_W-1:0] csr_write_data;

   brm_req_if req_port ();
   brm_rsp_if rsp_port ();

   product_scoreboard_type sb = new();

   // Predictor copy of operand_bits; follows every register write.
   logic [brm_pkg::CFG_W-1:0] width_setting;
   logic [brm_pkg::CFG_W-1:0] phase_width [RAND_PHASES] = '{
      5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd1, 5'd9, 5'd5, 5'd16};

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned hold_requests;
   int unsigned beats_in;
   int unsigned input_stalls;
   int unsigned widths_visited;

   booth_radix2_multiplier_core #(
      .MAX_WIDTH (MAX_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_port),
      .rsp_port         (rsp_port),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock, period 10.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the core hangs a handshake.
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random back-pressure, plus a long hold-off whenever the
   // stimulus asks for one. The hold is counted here so the sender keeps going.
   initial begin
      int unsigned holds_served;
      int unsigned hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_port.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_port.ready <= 1'b0;
         end else begin
            rsp_port.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Monitor: note every accepted operand beat, check every accepted result
   // beat. Sampled right at the edge, so values are those the core saw.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_port.valid && req_port.ready) begin
               sb.note_operands(req_port.multiplicand_bits, req_port.multiplier_bits,
                                width_setting);
               beats_in++;
            end else if (req_port.valid) begin
               input_stalls++;
            end
            if (rsp_port.valid && rsp_port.ready)
               sb.check_product(rsp_port.product_bits, rsp_port.negative,
                                rsp_port.magnitude);
         end
      end
   end

   // Offer one operand beat, idling first at the current sender rate, and
   // hold it until the core takes it.
   task automatic send_operands(input logic [brm_pkg::IN_W-1:0] mcand,
                                input logic [brm_pkg::IN_W-1:0] mplier);
      while ($urandom_range(99) < req_idle_pct) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid             <= 1'b1;
      req_port.multiplicand_bits <= mcand;
      req_port.multiplier_bits   <= mplier;
      @(posedge clock);
      while (req_port.ready !== 1'b1) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding product, then idle for extra_cycles.
   // The first edge lets the monitor note a beat accepted on the last edge.
   task automatic drain_products(input int unsigned extra_cycles);
      req_port.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   // Write operand_bits with the pipeline empty.
   task automatic write_width(input logic [brm_pkg::CFG_W-1:0] value);
      drain_products(2);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      width_setting = value;
      widths_visited++;
   endtask

   // Random operand: special low-n patterns a good part of the time, with
   // random garbage always kept in bit n and above.
   function automatic logic [brm_pkg::IN_W-1:0] pick_operand(input int unsigned n);
      logic [brm_pkg::IN_W-1:0] raw;
      logic [brm_pkg::IN_W-1:0] low;
      logic [brm_pkg::IN_W-1:0] mask;
      raw  = brm_pkg::IN_W'($urandom);
      mask = brm_pkg::IN_W'((32'd1 << n) - 32'd1);
      case ($urandom_range(7))
         0:       low = '0;
         1:       low = '1;
         2:       low = brm_pkg::IN_W'(32'd1 << (n - 1));
         3:       low = brm_pkg::IN_W'((32'd1 << (n - 1)) - 32'd1);
         default: low = brm_pkg::IN_W'($urandom);
      endcase
      return (raw & ~mask) | (low & mask);
   endfunction

   // Stimulus.
   initial begin
      int unsigned n;
      int unsigned i;
      int unsigned p;
      reset                      <= 1'b1;
      csr_write_enable           <= 1'b0;
      csr_write_data             <= '0;
      req_port.valid             <= 1'b0;
      req_port.multiplicand_bits <= '0;
      req_port.multiplier_bits   <= '0;
      width_setting  = brm_pkg::CFG_RESET;
      req_idle_pct   = 32;
      rsp_idle_pct   = 64;
      hold_requests  = 0;
      beats_in       = 0;
      input_stalls   = 0;
      widths_visited = 1;
      phase_width[RAND_PHASES-1] =
         brm_pkg::CFG_W'($urandom_range(MAX_WIDTH, 32'(brm_pkg::MIN_WIDTH)));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset width.
      for (i = 0; i < DIRECTED_16; i++)
         send_operands(DIR_MCAND[i], DIR_MPLIER[i]);

      // Narrow width with junk above the operand bits: only the low nibble counts.
      write_width(5'd4);
      send_operands(16'hFFF7, 16'hABC8);
      send_operands(16'h0008, 16'h0007);

      // Smallest width: minus two squared, and both signs.
      write_width(brm_pkg::MIN_WIDTH);
      send_operands(16'h0002, 16'h0002);
      send_operands(16'h0001, 16'h0002);
      send_operands(16'h0003, 16'h0003);
      send_operands(16'hFFFD, 16'h0001);

      // Width below range acts as the minimum.
      write_width(5'd0);
      send_operands(16'h0002, 16'h0003);

      // Width above range acts as MAX_WIDTH.
      write_width(5'd31);
      send_operands(16'h8000, 16'h8000);
      send_operands(16'h7FFF, 16'h8001);

      // Random phases: the first three with a slow sender and slower receiver,
      // the next three swapped, the last three with no idling at all.
      for (p = 0; p < RAND_PHASES; p++) begin
         write_width(phase_width[p]);
         case (p / 3)
            0: begin
               req_idle_pct = 32;
               rsp_idle_pct = 64;
            end
            1: begin
               req_idle_pct = 64;
               rsp_idle_pct = 32;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         n = product_scoreboard_type::effective_width(width_setting);
         for (i = 0; i < PHASE_BEATS; i++) begin
            // Starve the output while beats keep coming so the pipe fills up.
            if ((p == 6 || p == 8) && i == 10)
               hold_requests++;
            send_operands(pick_operand(n), pick_operand(n));
         end
      end

      drain_products(SETTLE_CYCLES);

      $display("Sent %0d operand beats over %0d operand_bits settings, checked %0d products;",
               beats_in, widths_visited, sb.checked);
      $display("input held off for %0d cycles by back-pressure.", input_stalls);
      if (sb.pending() != 0)
         $error("%0d products never arrived", sb.pending());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/brm_pkg.sv
rtl/core/brm_req_if.sv
rtl/core/brm_rsp_if.sv
rtl/core/brm_prep.sv
rtl/core/brm_booth_stage.sv
rtl/core/brm_finish.sv
rtl/core/booth_radix2_multiplier_core.sv
sim/tb.sv
